FILE: hw/rtl/fip_pkg.sv
// Shared types and constants of the fixed item pool allocator.
`default_nettype none

package fip_pkg;

	localparam int unsigned HANDLE_W  = 12;
	localparam int unsigned COUNT_W   = 13;
	localparam int unsigned ADDR_W    = 3;
	localparam int unsigned DATA_W    = 32;

	localparam logic [COUNT_W-1:0] BLOCK_MIN = 13'd2;
	localparam logic [COUNT_W-1:0] BLOCK_MAX = 13'd4096;
	localparam logic [COUNT_W-1:0] IPB_RESET = 13'd128;

	// register index, taken from paddr[2]
	localparam logic REG_IPB = 1'b0;

	localparam logic ACT_ALLOC = 1'b0;
	localparam logic ACT_FREE  = 1'b1;

	typedef logic [HANDLE_W-1:0] hport_t;
	typedef logic [COUNT_W-1:0]  count_t;

	typedef enum logic [1:0] {
		STAT_ALLOC = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_FREED = 2'd2
	} stat_t;

	typedef struct packed {
		hport_t handle;
		stat_t  status;
		count_t count;
	} result_t;

	typedef struct packed {
		logic link_re;
		logic link_we;
		logic tail_re;
		logic tail_we;
	} mem_ctl_t;

endpackage

`default_nettype wire

FILE: hw/rtl/fixed_item_pool_allocator_core.sv
// Top level of the fixed item pool allocator: register port, output register, checks.
`default_nettype none

// Hands out and takes back handles of a pool of POOL_ITEMS fixed-size items. An allocate
// is served from the local free list, then from the block being carved, then by taking a
// whole chunk from the reuse list, then by opening a fresh block; status 1 means the pool
// is exhausted. A free pushes the handle onto the local list; once that list holds twice
// the block size, its oldest chunk moves to the reuse list. One item is worked on at a
// time. The work per item follows the chain of dependent, registered reads of the link
// and tail memories: a carve, fresh block or out-of-items answer reads none, a local pop
// the head's link, a chunk take the link and tail of the reuse head and then the link of
// that tail, and a free the tail of the local head, then, when a chunk leaves, the link
// of that tail and the tail of the chunk after it. The memories are not cleared after
// reset and need no clearing pass. A finished result waits in the output register while
// the next item is accepted. items_per_block (register 0, byte address 0) is to be
// written only while the block is idle; it is used clamped to 2..4096.
module fixed_item_pool_allocator_core #(
	parameter int unsigned POOL_ITEMS = 4096
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            psel,
	input  wire                            penable,
	input  wire                            pwrite,
	input  wire  [fip_pkg::ADDR_W-1:0]     paddr,
	input  wire  [fip_pkg::DATA_W-1:0]     pwdata,
	output logic [fip_pkg::DATA_W-1:0]     prdata,
	output logic                           pready,
	input  wire                            in_valid,
	output logic                           in_ready,
	input  wire                            action,
	input  wire  [fip_pkg::HANDLE_W-1:0]   item_handle,
	output logic                           out_valid,
	input  wire                            out_ready,
	output logic [fip_pkg::HANDLE_W-1:0]   result_handle,
	output logic [1:0]                     status,
	output logic [fip_pkg::COUNT_W-1:0]    free_count
);

	localparam int unsigned HW = $clog2(POOL_ITEMS);
	localparam int unsigned LW = $clog2(POOL_ITEMS + 1);

	fip_pkg::count_t   ipb_q;
	logic              out_valid_q;
	fip_pkg::result_t  out_res_q;

	logic              res_valid;
	logic              res_ready;
	fip_pkg::result_t  res;
	fip_pkg::mem_ctl_t mem;
	logic [HW-1:0]     link_raddr;
	logic [HW-1:0]     link_waddr;
	logic [LW-1:0]     link_wdata;
	logic [LW-1:0]     link_rdata;
	logic [HW-1:0]     tail_raddr;
	logic [HW-1:0]     tail_waddr;
	logic [HW-1:0]     tail_wdata;
	logic [HW-1:0]     tail_rdata;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == fip_pkg::REG_IPB) ? fip_pkg::DATA_W'(ipb_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ipb_q <= fip_pkg::IPB_RESET;
		end else if (psel && penable && pwrite && pready && (paddr[2] == fip_pkg::REG_IPB)) begin
			ipb_q <= pwdata[fip_pkg::COUNT_W-1:0];
		end
	end

	// output register frees the sequencer while the item waits downstream
	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_res_q   <= '0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
			out_res_q   <= res;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid     = out_valid_q;
	assign result_handle = out_res_q.handle;
	assign status        = out_res_q.status;
	assign free_count    = out_res_q.count;

	fip_ctrl #(
		.POOL_ITEMS (POOL_ITEMS)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.ipb         (ipb_q),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.action      (action),
		.item_handle (item_handle),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.res         (res),
		.mem         (mem),
		.link_raddr  (link_raddr),
		.link_waddr  (link_waddr),
		.link_wdata  (link_wdata),
		.link_rdata  (link_rdata),
		.tail_raddr  (tail_raddr),
		.tail_waddr  (tail_waddr),
		.tail_wdata  (tail_wdata),
		.tail_rdata  (tail_rdata)
	);

	fip_store #(
		.POOL_ITEMS (POOL_ITEMS)
	) u_store (
		.clk        (clk),
		.ctl        (mem),
		.link_raddr (link_raddr),
		.link_waddr (link_waddr),
		.link_wdata (link_wdata),
		.link_rdata (link_rdata),
		.tail_raddr (tail_raddr),
		.tail_waddr (tail_waddr),
		.tail_wdata (tail_wdata),
		.tail_rdata (tail_rdata)
	);

	// the sequencer never offers a result while it takes a new item
	a_ready_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !res_valid)
		else $error("item accepted while a result is pending");

	// a result handed to the output register returns the sequencer to idle
	a_result_then_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ready |=> in_ready)
		else $error("sequencer did not return to idle");

	// only a successful allocate carries a handle
	a_handle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != fip_pkg::STAT_ALLOC) |-> result_handle == '0)
		else $error("handle set on a result that is not an allocation");

endmodule

`default_nettype wire

FILE: hw/rtl/fip_store.sv
// Link and chunk-tail memories, one read and one write port each, registered read.
`default_nettype none

module fip_store #(
	parameter int unsigned POOL_ITEMS = 4096,
	localparam int unsigned HW = $clog2(POOL_ITEMS),
	localparam int unsigned LW = $clog2(POOL_ITEMS + 1)
) (
	input  wire                 clk,
	input  wire fip_pkg::mem_ctl_t ctl,
	input  wire  [HW-1:0]       link_raddr,
	input  wire  [HW-1:0]       link_waddr,
	input  wire  [LW-1:0]       link_wdata,
	output logic [LW-1:0]       link_rdata,
	input  wire  [HW-1:0]       tail_raddr,
	input  wire  [HW-1:0]       tail_waddr,
	input  wire  [HW-1:0]       tail_wdata,
	output logic [HW-1:0]       tail_rdata
);

	logic [LW-1:0] link_mem [POOL_ITEMS];
	logic [HW-1:0] tail_mem [POOL_ITEMS];

	always_ff @(posedge clk) begin
		if (ctl.link_we) begin
			link_mem[link_waddr] <= link_wdata;
		end
		if (ctl.link_re) begin
			link_rdata <= link_mem[link_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.tail_we) begin
			tail_mem[tail_waddr] <= tail_wdata;
		end
		if (ctl.tail_re) begin
			tail_rdata <= tail_mem[tail_raddr];
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/fip_ctrl.sv
// Allocator sequencer: list heads, carve state and read-modify-write of the memories.
`default_nettype none

module fip_ctrl #(
	parameter int unsigned POOL_ITEMS = 4096,
	localparam int unsigned HW = $clog2(POOL_ITEMS),
	localparam int unsigned LW = $clog2(POOL_ITEMS + 1)
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire  [fip_pkg::COUNT_W-1:0] ipb,
	input  wire                    in_valid,
	output logic                   in_ready,
	input  wire                    action,
	input  wire  [fip_pkg::HANDLE_W-1:0] item_handle,
	output logic                   res_valid,
	input  wire                    res_ready,
	output fip_pkg::result_t       res,
	output fip_pkg::mem_ctl_t      mem,
	output logic [HW-1:0]          link_raddr,
	output logic [HW-1:0]          link_waddr,
	output logic [LW-1:0]          link_wdata,
	input  wire  [LW-1:0]          link_rdata,
	output logic [HW-1:0]          tail_raddr,
	output logic [HW-1:0]          tail_waddr,
	output logic [HW-1:0]          tail_wdata,
	input  wire  [HW-1:0]          tail_rdata
);

	localparam int unsigned CW = fip_pkg::COUNT_W;
	localparam int unsigned SW = ((LW > CW) ? LW : CW) + 1;

	typedef logic [HW-1:0] hnd_t;
	typedef logic [LW-1:0] lnk_t;
	typedef logic [SW-1:0] sum_t;
	typedef logic [CW:0]   cntx_t;

	localparam lnk_t NULLC = lnk_t'(POOL_ITEMS);

	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_POP  = 8'b0000_0010,
		S_RU1  = 8'b0000_0100,
		S_RU2  = 8'b0000_1000,
		S_FW   = 8'b0001_0000,
		S_FM1  = 8'b0010_0000,
		S_FM2  = 8'b0100_0000,
		S_OUT  = 8'b1000_0000
	} state_t;

	state_t            state_q;
	lnk_t              lh_q;
	fip_pkg::count_t   cnt_q;
	logic              carve_act_q;
	fip_pkg::count_t   carve_idx_q;
	hnd_t              carve_base_q;
	lnk_t              fresh_q;
	lnk_t              rh_q;

	hnd_t              n_q;
	hnd_t              tv_q;
	hnd_t              t_q;
	lnk_t              lnk_q;
	lnk_t              g_q;
	cntx_t             cntp_q;
	fip_pkg::result_t  res_q;

	fip_pkg::count_t   blk;
	cntx_t             blk2;
	logic              lh_ok;
	logic              rh_ok;
	logic              n_ok;
	hnd_t              n_in;
	lnk_t              lhv;
	hnd_t              carve_sum;
	fip_pkg::count_t   carve_nxt;
	sum_t              fresh_sum;
	logic              fresh_fit;
	cntx_t             cnt_inc;
	logic              move;
	logic              rel;
	hnd_t              tv;
	hnd_t              tail_fin;
	lnk_t              g;
	logic              g_ok;
	fip_pkg::count_t   cnt_mv;

	always_comb begin
		if (ipb < fip_pkg::BLOCK_MIN) begin
			blk = fip_pkg::BLOCK_MIN;
		end else if (ipb > fip_pkg::BLOCK_MAX) begin
			blk = fip_pkg::BLOCK_MAX;
		end else begin
			blk = ipb;
		end
	end

	assign blk2      = {blk, 1'b0};
	assign lh_ok     = lh_q < NULLC;
	assign rh_ok     = rh_q < NULLC;
	assign lhv       = lh_ok ? lh_q : NULLC;
	assign n_in      = hnd_t'(item_handle);
	assign n_ok      = 32'(item_handle) < 32'(POOL_ITEMS);
	assign carve_sum = carve_base_q + hnd_t'(carve_idx_q);
	assign carve_nxt = carve_idx_q + fip_pkg::count_t'(1);
	assign fresh_sum = sum_t'(fresh_q) + sum_t'(blk);
	assign fresh_fit = fresh_sum <= sum_t'(POOL_ITEMS);
	assign cnt_inc   = cntx_t'(cnt_q) + cntx_t'(1);

	// free path: tail of the chunk n joins, and whether a chunk leaves
	assign move      = cntp_q >= blk2;
	assign rel       = cntp_q == (cntx_t'(blk) + cntx_t'(1));
	assign tv        = lh_ok ? tail_rdata : n_q;
	assign tail_fin  = (!move && rel) ? n_q : tv;
	// oldest chunk head; forwarded when the tail is the item just written
	assign g         = (tv_q == n_q) ? lhv : link_rdata;
	assign g_ok      = g < NULLC;
	assign cnt_mv    = fip_pkg::count_t'(cntp_q - cntx_t'(blk));

	assign in_ready  = state_q == S_IDLE;
	assign res_valid = state_q == S_OUT;
	assign res       = res_q;

	always_comb begin
		mem        = '0;
		link_raddr = '0;
		link_waddr = '0;
		link_wdata = '0;
		tail_raddr = '0;
		tail_waddr = '0;
		tail_wdata = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (action == fip_pkg::ACT_FREE) begin
						if (n_ok && lh_ok) begin
							mem.tail_re = 1'b1;
							tail_raddr  = hnd_t'(lh_q);
						end
					end else if (lh_ok) begin
						mem.link_re = 1'b1;
						link_raddr  = hnd_t'(lh_q);
					end else if (!carve_act_q && rh_ok) begin
						mem.link_re = 1'b1;
						mem.tail_re = 1'b1;
						link_raddr  = hnd_t'(rh_q);
						tail_raddr  = hnd_t'(rh_q);
					end
				end
			end
			S_RU1: begin
				mem.link_re = 1'b1;
				link_raddr  = tail_rdata;
			end
			S_RU2: begin
				mem.link_we = 1'b1;
				link_waddr  = t_q;
				link_wdata  = NULLC;
			end
			S_FW: begin
				mem.link_we = 1'b1;
				link_waddr  = n_q;
				link_wdata  = lhv;
				mem.tail_we = 1'b1;
				tail_waddr  = n_q;
				tail_wdata  = tail_fin;
				if (move && (tv != n_q)) begin
					mem.link_re = 1'b1;
					link_raddr  = tv;
				end
			end
			S_FM1: begin
				mem.link_we = 1'b1;
				link_waddr  = tv_q;
				link_wdata  = NULLC;
				if (g_ok) begin
					mem.tail_re = 1'b1;
					tail_raddr  = hnd_t'(g);
				end
			end
			S_FM2: begin
				mem.link_we = 1'b1;
				link_waddr  = tail_rdata;
				link_wdata  = rh_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			lh_q         <= NULLC;
			cnt_q        <= '0;
			carve_act_q  <= 1'b0;
			carve_idx_q  <= '0;
			carve_base_q <= '0;
			fresh_q      <= '0;
			rh_q         <= NULLC;
			n_q          <= '0;
			tv_q         <= '0;
			t_q          <= '0;
			lnk_q        <= '0;
			g_q          <= '0;
			cntp_q       <= '0;
			res_q        <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						if (action == fip_pkg::ACT_FREE) begin
							n_q    <= n_in;
							cntp_q <= cnt_inc;
							if (!n_ok) begin
								res_q   <= '{handle: '0, status: fip_pkg::STAT_FREED,
									count: cnt_q};
								state_q <= S_OUT;
							end else begin
								state_q <= S_FW;
							end
						end else if (lh_ok) begin
							state_q <= S_POP;
						end else if (carve_act_q) begin
							res_q       <= '{handle: fip_pkg::hport_t'(carve_sum),
								status: fip_pkg::STAT_ALLOC, count: cnt_q};
							carve_idx_q <= carve_nxt;
							if (carve_nxt >= blk) begin
								carve_act_q <= 1'b0;
							end
							state_q     <= S_OUT;
						end else if (rh_ok) begin
							state_q <= S_RU1;
						end else if (fresh_fit) begin
							res_q        <= '{handle: fip_pkg::hport_t'(hnd_t'(fresh_q)),
								status: fip_pkg::STAT_ALLOC, count: cnt_q};
							carve_base_q <= hnd_t'(fresh_q);
							carve_idx_q  <= fip_pkg::count_t'(1);
							carve_act_q  <= 1'b1;
							fresh_q      <= lnk_t'(fresh_sum);
							state_q      <= S_OUT;
						end else begin
							res_q   <= '{handle: '0, status: fip_pkg::STAT_EMPTY,
								count: cnt_q};
							state_q <= S_OUT;
						end
					end
				end
				S_POP: begin
					lh_q    <= link_rdata;
					cnt_q   <= (cnt_q == '0) ? '0 : cnt_q - fip_pkg::count_t'(1);
					res_q   <= '{handle: fip_pkg::hport_t'(hnd_t'(lh_q)),
						status: fip_pkg::STAT_ALLOC,
						count: (cnt_q == '0) ? '0 : cnt_q - fip_pkg::count_t'(1)};
					state_q <= S_OUT;
				end
				S_RU1: begin
					t_q     <= tail_rdata;
					lnk_q   <= link_rdata;
					state_q <= S_RU2;
				end
				S_RU2: begin
					rh_q    <= link_rdata;
					// a chunk of one item has its own link cleared
					lh_q    <= (t_q == hnd_t'(rh_q)) ? NULLC : lnk_q;
					cnt_q   <= blk - fip_pkg::count_t'(1);
					res_q   <= '{handle: fip_pkg::hport_t'(hnd_t'(rh_q)),
						status: fip_pkg::STAT_ALLOC, count: blk - fip_pkg::count_t'(1)};
					state_q <= S_OUT;
				end
				S_FW: begin
					tv_q <= tv;
					if (move) begin
						state_q <= S_FM1;
					end else begin
						lh_q    <= lnk_t'(n_q);
						cnt_q   <= fip_pkg::count_t'(cntp_q);
						res_q   <= '{handle: '0, status: fip_pkg::STAT_FREED,
							count: fip_pkg::count_t'(cntp_q)};
						state_q <= S_OUT;
					end
				end
				S_FM1: begin
					g_q <= g;
					if (g_ok) begin
						state_q <= S_FM2;
					end else begin
						lh_q    <= lnk_t'(n_q);
						cnt_q   <= cnt_mv;
						res_q   <= '{handle: '0, status: fip_pkg::STAT_FREED, count: cnt_mv};
						state_q <= S_OUT;
					end
				end
				S_FM2: begin
					rh_q    <= g_q;
					lh_q    <= lnk_t'(n_q);
					cnt_q   <= cnt_mv;
					res_q   <= '{handle: '0, status: fip_pkg::STAT_FREED, count: cnt_mv};
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: dv/fixed_item_pool_allocator_core_tb.sv
// Testbench of the fixed item pool allocator core: directed and random items, predictor check.
module fixed_item_pool_allocator_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned POOL      = 4096;
	localparam int unsigned NULLH     = POOL;
	localparam int unsigned CMASK     = 'h1FFF;
	localparam int unsigned HMASK     = 'hFFF;
	localparam int          LIMIT     = 300000;
	localparam int          LONG_HOLD = 80;

	// Free-list allocator predictor with its own copy of the link and chunk tail stores.
	class free_list_scoreboard;
		logic [fip_pkg::COUNT_W-1:0]  link_mem [POOL];
		logic [fip_pkg::HANDLE_W-1:0] tail_mem [POOL];
		int unsigned head, count, c_index, c_base, f_base, reuse, ipb;
		bit c_active;
		fip_pkg::result_t due_q[$];
		int errors, n_alloc, n_empty, n_freed, n_moves, n_takes, n_seen;

		function new();
			foreach (link_mem[i]) begin
				link_mem[i] = '0;
				tail_mem[i] = '0;
			end
			head = NULLH;
			count = 0;
			c_active = 0;
			c_index = 0;
			c_base = 0;
			f_base = 0;
			reuse = NULLH;
			ipb = 32'(fip_pkg::IPB_RESET);
		endfunction

		function void set_block(logic [fip_pkg::DATA_W-1:0] v);
			ipb = v & CMASK;
		endfunction

		function int unsigned block_size();
			int unsigned b;
			b = ipb;
			if (b < 32'(fip_pkg::BLOCK_MIN)) b = 32'(fip_pkg::BLOCK_MIN);
			if (b > 32'(fip_pkg::BLOCK_MAX)) b = 32'(fip_pkg::BLOCK_MAX);
			return b;
		endfunction

		function int pending();
			return due_q.size();
		endfunction

		// works out the answer to an accepted item and queues it
		function fip_pkg::result_t take_request(logic act, fip_pkg::hport_t h);
			int unsigned b, hv, t, g, cnt;
			fip_pkg::result_t r;
			b = block_size();
			hv = 0;
			r.status = fip_pkg::STAT_FREED;
			if (act == fip_pkg::ACT_ALLOC) begin
				r.status = fip_pkg::STAT_ALLOC;
				if (head < POOL) begin
					hv = head;
					head = 32'(link_mem[hv]);
					if (count > 0) count--;
				end else if (c_active) begin
					hv = c_base + c_index;
					c_index = (c_index + 1) & CMASK;
					if (c_index >= b) c_active = 0;
				end else if (reuse < POOL) begin
					hv = reuse;
					t = 32'(tail_mem[hv]);
					reuse = 32'(link_mem[t]);
					link_mem[t] = fip_pkg::count_t'(NULLH);
					head = 32'(link_mem[hv]);
					count = (b - 1) & CMASK;
					n_takes++;
				end else if (f_base + b <= POOL) begin
					hv = f_base;
					c_base = f_base & HMASK;
					c_index = 1;
					c_active = 1;
					f_base = (f_base + b) & CMASK;
				end else begin
					r.status = fip_pkg::STAT_EMPTY;
				end
				if (r.status == fip_pkg::STAT_ALLOC) n_alloc++;
				else n_empty++;
			end else begin
				if (head < POOL) begin
					link_mem[h] = fip_pkg::count_t'(head);
					tail_mem[h] = tail_mem[head];
				end else begin
					link_mem[h] = fip_pkg::count_t'(NULLH);
					tail_mem[h] = h;
				end
				cnt = count + 1;
				if (cnt >= 2 * b) begin
					// oldest chunk leaves for the reuse list, if there is one
					t = 32'(tail_mem[h]);
					g = 32'(link_mem[t]);
					link_mem[t] = fip_pkg::count_t'(NULLH);
					if (g < POOL) begin
						link_mem[tail_mem[g]] = fip_pkg::count_t'(reuse);
						reuse = g;
					end
					cnt -= b;
					n_moves++;
				end else if (cnt == b + 1) begin
					tail_mem[h] = h;
				end
				head = h;
				count = cnt & CMASK;
				n_freed++;
			end
			r.handle = fip_pkg::hport_t'(hv & HMASK);
			r.count = fip_pkg::count_t'(count);
			due_q.push_back(r);
			return r;
		endfunction

		function void match_response(fip_pkg::hport_t h, logic [1:0] st, fip_pkg::count_t c);
			fip_pkg::result_t r;
			n_seen++;
			if (due_q.size() == 0) begin
				errors++;
				$display("%0t: result with none expected: handle %0d status %0d count %0d",
					$time, h, st, c);
				return;
			end
			r = due_q.pop_front();
			if (h !== r.handle) begin
				errors++;
				$display("%0t: result_handle expected %0d actual %0d", $time, r.handle, h);
			end
			if (st !== r.status) begin
				errors++;
				$display("%0t: status expected %0d actual %0d", $time, r.status, st);
			end
			if (c !== r.count) begin
				errors++;
				$display("%0t: free_count expected %0d actual %0d", $time, r.count, c);
			end
		endfunction
	endclass

	logic                          clk;
	logic                          arst_n;
	logic                          psel;
	logic                          penable;
	logic                          pwrite;
	logic [fip_pkg::ADDR_W-1:0]    paddr;
	logic [fip_pkg::DATA_W-1:0]    pwdata;
	logic [fip_pkg::DATA_W-1:0]    prdata;
	logic                          pready;
	logic                          in_valid;
	logic                          in_ready;
	logic                          action;
	fip_pkg::hport_t               item_handle;
	logic                          out_valid;
	logic                          out_ready;
	fip_pkg::hport_t               result_handle;
	logic [1:0]                    status;
	fip_pkg::count_t               free_count;

	free_list_scoreboard sb = new();
	fip_pkg::hport_t live_q[$];
	bit          calm;
	bit          hold_req;
	int          cycles;
	int unsigned plan_ipb [8] = '{5, 2, 32'h0001_0003, 8, 4096, 1, 16, 32'hFFFF_E004};

	fixed_item_pool_allocator_core #(.POOL_ITEMS(POOL)) u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.action        (action),
		.item_handle   (item_handle),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.result_handle (result_handle),
		.status        (status),
		.free_count    (free_count)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("fixed_item_pool_allocator_core test failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.match_response(result_handle, status, free_count);
	end

	// receiver: random stalls, one long hold-off on request
	initial begin : rx_ctl
		int n;
		out_ready <= 1'b0;
		@(posedge clk);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				n = $urandom_range(1, 7);
				out_ready <= 1'b0;
				repeat (n) @(posedge clk);
			end else begin
				n = $urandom_range(1, 12);
				out_ready <= 1'b1;
				repeat (n) @(posedge clk);
			end
		end
	end

	task automatic send_item(input logic act, input fip_pkg::hport_t h);
		int gap;
		int idx[$];
		fip_pkg::result_t r;
		if (!calm && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 7);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		action      <= act;
		item_handle <= h;
		do @(posedge clk); while (!in_ready);
		r = sb.take_request(act, h);
		if (act == fip_pkg::ACT_FREE) begin
			idx = live_q.find_first_index(x) with (x == h);
			if (idx.size() > 0) live_q.delete(idx[0]);
		end else if (r.status == fip_pkg::STAT_ALLOC) begin
			live_q.push_back(r.handle);
		end
	endtask

	// sender holds back until every answer is in, then lets the block settle
	task automatic settle();
		in_valid <= 1'b0;
		while (sb.pending() > 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [fip_pkg::DATA_W-1:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {fip_pkg::REG_IPB, 2'b00};
		pwdata  <= v;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		sb.set_block(v);
		// read back the stored block size
		@(posedge clk);
		if (prdata !== (v & CMASK)) begin
			sb.errors++;
			$display("%0t: prdata expected %0d actual %0d", $time, v & CMASK, prdata);
		end
	endtask

	// alternating bursts of allocations and frees of live handles, with a little noise
	task automatic run_phase(input int n_items);
		int sent, burst, b;
		fip_pkg::hport_t h;
		sent = 0;
		b = sb.block_size();
		if (b > 16) b = 8;
		while (sent < n_items) begin
			burst = $urandom_range(1, 3 * b);
			for (int i = 0; i < burst && sent < n_items; i++) begin
				send_item(fip_pkg::ACT_ALLOC, fip_pkg::hport_t'($urandom));
				sent++;
			end
			burst = $urandom_range(1, live_q.size() + 1);
			for (int i = 0; i < burst && sent < n_items; i++) begin
				if (live_q.size() == 0 || $urandom_range(0, 19) == 0)
					h = fip_pkg::hport_t'($urandom);
				else
					h = live_q[$urandom_range(0, live_q.size() - 1)];
				send_item(fip_pkg::ACT_FREE, h);
				sent++;
			end
		end
	endtask

	initial begin : stimulus
		calm = 1'b0;
		hold_req = 1'b0;
		arst_n      <= 1'b0;
		in_valid    <= 1'b0;
		action      <= fip_pkg::ACT_ALLOC;
		item_handle <= '0;
		psel        <= 1'b0;
		penable     <= 1'b0;
		pwrite      <= 1'b0;
		paddr       <= '0;
		pwdata      <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fresh block, top and bottom handles through the local list, carve resumes
		send_item(fip_pkg::ACT_ALLOC, '1);
		send_item(fip_pkg::ACT_ALLOC, '0);
		send_item(fip_pkg::ACT_FREE, 12'd4095);
		send_item(fip_pkg::ACT_FREE, 12'd0);
		send_item(fip_pkg::ACT_ALLOC, fip_pkg::hport_t'($urandom));
		send_item(fip_pkg::ACT_ALLOC, fip_pkg::hport_t'($urandom));
		send_item(fip_pkg::ACT_ALLOC, fip_pkg::hport_t'($urandom));

		// shrink the block mid-carve: the carve hands out one more item and then ends
		settle();
		write_reg(32'd2);
		repeat (3) send_item(fip_pkg::ACT_ALLOC, fip_pkg::hport_t'($urandom));

		settle();
		write_reg(32'd4);
		send_item(fip_pkg::ACT_FREE, 12'd3);
		send_item(fip_pkg::ACT_FREE, 12'd128);
		send_item(fip_pkg::ACT_FREE, 12'd129);

		// zero clamps to 2; the chunk move then finds no older chunk, pops run the count dry
		settle();
		write_reg(32'd0);
		send_item(fip_pkg::ACT_FREE, 12'd1);
		repeat (4) send_item(fip_pkg::ACT_ALLOC, fip_pkg::hport_t'($urandom));

		// oversized block clamps to the whole pool: nothing fresh fits
		settle();
		write_reg(32'd8191);
		repeat (2) send_item(fip_pkg::ACT_ALLOC, fip_pkg::hport_t'($urandom));

		for (int p = 0; p < 8; p++) begin
			settle();
			write_reg(plan_ipb[p]);
			if (p == 2) hold_req = 1'b1;
			calm = (p == 7);
			run_phase(p == 4 ? 30 : 60);
		end
		settle();

		$display("ran %0d allocations, %0d out-of-items answers and %0d frees",
			sb.n_alloc, sb.n_empty, sb.n_freed);
		$display("over a spread of block sizes; %0d chunk moves, %0d taken back, %0d checked",
			sb.n_moves, sb.n_takes, sb.n_seen);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("fixed_item_pool_allocator_core test passed");
		end else begin
			$display("fixed_item_pool_allocator_core test failed");
		end
		$finish;
	end

endmodule
